>>> sv/i2c_eeprom_slave_write_buffer_assert.svh
// Assertion macros for the I2C EEPROM slave write buffer.
// Expects signals named clk and rst in the scope of each use.
`ifndef I2C_EEPROM_SLAVE_WRITE_BUFFER_ASSERT_SVH
`define I2C_EEPROM_SLAVE_WRITE_BUFFER_ASSERT_SVH
`ifndef SYNTHESIS
// Condition holds at every edge outside reset
`define I2CESW_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Antecedent implies consequent in the same cycle
`define I2CESW_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Antecedent implies consequent in the next cycle
`define I2CESW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define I2CESW_ASSERT_ALWAYS(label, cond, msg)
`define I2CESW_ASSERT_IMPLY(label, ante, cons, msg)
`define I2CESW_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> sv/i2cesw_pkg.sv
// Shared codes for the I2C EEPROM slave write buffer.
// No dependencies.
package i2cesw_pkg;

  // Input action codes
  localparam logic [2:0] ACT_MATCH_WRITE = 3'd0;
  localparam logic [2:0] ACT_MATCH_READ  = 3'd1;
  localparam logic [2:0] ACT_STOP        = 3'd2;
  localparam logic [2:0] ACT_BUS_WRITE   = 3'd3;
  localparam logic [2:0] ACT_BUS_READ    = 3'd4;
  localparam logic [2:0] ACT_LOCK_CODE   = 3'd5;
  localparam logic [2:0] ACT_FLUSH_POLL  = 3'd6;
  localparam logic [2:0] ACT_LOCAL_WRITE = 3'd7;

  // Lock sequence characters
  localparam logic [7:0] CHAR_L = 8'h4C;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_O = 8'h4F;
  localparam logic [7:0] CHAR_K = 8'h4B;

  // Lock prefix codes
  localparam logic [1:0] PFX_NONE = 2'd0;
  localparam logic [1:0] PFX_L    = 2'd1;
  localparam logic [1:0] PFX_C    = 2'd2;

  // Address phase codes
  localparam logic [1:0] PH_DATA = 2'd0;
  localparam logic [1:0] PH_LOW  = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;

  // Beat widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

endpackage

>>> sv/i2c_eeprom_slave_write_buffer.sv
// I2C EEPROM slave write buffer: committed byte store plus a deferred write queue.
// Each beat yields a result beat before the next is taken. Control actions go straight
// to the result; a bus read passes S_RDADDR and S_RDDATA, an address reduction S_MOD,
// a queued write S_ENQ and a commit S_FLUSH. A result waiting in the output register
// holds the next one. Synchronous reset, then a clearing pass writes 0xFF to the store.
// Depends on i2cesw_pkg, i2cesw_ram and the assertion macro header.
`include "i2c_eeprom_slave_write_buffer_assert.svh"
module i2c_eeprom_slave_write_buffer #(
  parameter int MEM_BYTES   = 1024,
  parameter int QUEUE_DEPTH = 128
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // action [2:0], data_byte [10:3], local_address [20:11], zero [23:21]
  input  logic [i2cesw_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // read_data [7:0], write_locked [8], pending_count [16:9], flushed [17], zero [23:18]
  output logic [i2cesw_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  import i2cesw_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Reduction constants: store size and floor(2^24 / MEM_BYTES)
  localparam logic [16:0] MOD_M     = 17'(MEM_BYTES);
  localparam logic [16:0] MOD_RECIP = 17'((1 << 24) / MEM_BYTES);

  // Sequencer states
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_ENQ    = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;
  localparam logic [2:0] S_RDADDR = 3'd5;
  localparam logic [2:0] S_RDDATA = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0]    state;
  logic [AW-1:0] clr_idx;
  logic [AW-1:0] pointer;
  logic [1:0]    phase;
  logic [7:0]    held_byte;
  logic [CW-1:0] count;
  logic          in_trans;
  logic          protect;
  logic [1:0]    prefix;

  // Working registers
  logic [15:0]   mod_val;
  logic          mod_step;
  logic [7:0]    mod_quo;
  logic          mod_to_ptr;
  logic [AW-1:0] enq_off;
  logic [7:0]    enq_data;
  logic          enq_after;
  logic [CW-1:0] fl_idx;
  logic          fl_pend;
  logic [7:0]    res_rd;
  logic          res_flushed;

  // Input beat fields
  logic [2:0] in_action;
  logic [7:0] in_data;
  logic [9:0] in_local;
  assign in_action = s_axis_tdata[2:0];
  assign in_data   = s_axis_tdata[10:3];
  assign in_local  = s_axis_tdata[20:11];

  assign s_axis_tready = (state == S_IDLE);

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  // Memory ports
  logic            st_we;
  logic [AW-1:0]   st_addr;
  logic [7:0]      st_wdata;
  logic [7:0]      st_rdata;
  logic            q_we;
  logic [QW-1:0]   q_addr;
  logic [AW+7:0]   q_wdata;
  logic [AW+7:0]   q_rdata;

  i2cesw_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_store (
    .clk   (clk),
    .we    (st_we),
    .addr  (st_addr),
    .wdata (st_wdata),
    .rdata (st_rdata)
  );

  i2cesw_ram #(.WIDTH(AW + 8), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .addr  (q_addr),
    .wdata (q_wdata),
    .rdata (q_rdata)
  );

  // Store port: clearing pass, queue commit, or bus read
  always_comb begin
    st_we    = (state == S_CLEAR) || ((state == S_FLUSH) && fl_pend);
    st_wdata = (state == S_CLEAR) ? 8'hFF : q_rdata[7:0];
    if (state == S_CLEAR) begin
      st_addr = clr_idx;
    end else if (state == S_FLUSH) begin
      st_addr = q_rdata[AW+7:8];
    end else begin
      st_addr = pointer;
    end
  end

  // Queue port: append at the tail, or walk from the head during a commit
  assign q_we    = (state == S_ENQ);
  assign q_addr  = (state == S_ENQ) ? count[QW-1:0] : fl_idx[QW-1:0];
  assign q_wdata = {enq_off, enq_data};

  // Reduce modulo MEM_BYTES: estimate the quotient by reciprocal multiply
  // (low by at most one), then subtract and correct once
  logic [31:0] mod_prod;
  logic [16:0] mod_back;
  logic [16:0] mod_rem;
  logic [16:0] mod_fix;
  assign mod_prod = {16'd0, mod_val} * {15'd0, MOD_RECIP};
  assign mod_back = {9'd0, mod_quo} * MOD_M;
  assign mod_rem  = {1'b0, mod_val} - mod_back;
  assign mod_fix  = (mod_rem >= MOD_M) ? mod_rem - MOD_M : mod_rem;

  logic [AW-1:0] ptr_inc;
  assign ptr_inc = (pointer == AW'(MEM_BYTES - 1)) ? '0 : pointer + 1'b1;

  logic q_full;
  assign q_full = (count == CW'(QUEUE_DEPTH));

  logic fl_issue;
  logic fl_done;
  assign fl_issue = (fl_idx < count);
  assign fl_done  = !fl_issue && !fl_pend;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      pointer       <= '0;
      phase         <= PH_DATA;
      held_byte     <= '0;
      count         <= '0;
      in_trans      <= 1'b0;
      protect       <= 1'b1;
      prefix        <= PFX_NONE;
      fl_pend       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // drain the result register unless a new result replaces it
      if (m_axis_tvalid && m_axis_tready && state != S_EMIT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AW'(MEM_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_rd      <= 8'd0;
            res_flushed <= 1'b0;
            enq_data    <= in_data;
            enq_after   <= 1'b0;
            fl_idx      <= '0;
            fl_pend     <= 1'b0;
            state       <= S_EMIT;
            case (in_action)
              ACT_MATCH_WRITE: begin
                phase    <= PH_HIGH;
                in_trans <= 1'b1;
              end
              ACT_MATCH_READ: begin
                in_trans <= 1'b1;
              end
              ACT_STOP: begin
                in_trans <= 1'b0;
              end
              ACT_BUS_WRITE: begin
                if (phase == PH_HIGH) begin
                  held_byte <= in_data;
                  phase     <= PH_LOW;
                end else if (phase == PH_LOW) begin
                  mod_val    <= {held_byte, in_data};
                  mod_step   <= 1'b0;
                  mod_to_ptr <= 1'b1;
                  state      <= S_MOD;
                end else begin
                  pointer <= ptr_inc;
                  if (!protect) begin
                    enq_off <= pointer;
                    if (q_full) begin
                      res_flushed <= 1'b1;
                      enq_after   <= 1'b1;
                      state       <= S_FLUSH;
                    end else begin
                      state <= S_ENQ;
                    end
                  end
                end
              end
              ACT_BUS_READ: begin
                if (phase == PH_LOW) begin
                  pointer <= AW'(held_byte);
                  phase   <= PH_DATA;
                end
                state <= S_RDADDR;
              end
              ACT_LOCK_CODE: begin
                if (in_data == CHAR_L) begin
                  prefix <= PFX_L;
                end else if (in_data == CHAR_C) begin
                  prefix <= PFX_C;
                end else begin
                  if (in_data == CHAR_O && prefix == PFX_L) begin
                    protect <= 1'b1;
                  end else if (in_data == CHAR_K && prefix == PFX_C) begin
                    protect <= 1'b0;
                  end
                  prefix <= PFX_NONE;
                end
              end
              ACT_FLUSH_POLL: begin
                if (count != '0 && !in_trans) begin
                  res_flushed <= 1'b1;
                  state       <= S_FLUSH;
                end
              end
              default: begin
                mod_val    <= 16'(in_local);
                mod_step   <= 1'b0;
                mod_to_ptr <= 1'b0;
                state      <= S_MOD;
              end
            endcase
          end
        end
        S_MOD: begin
          if (!mod_step) begin
            // register the quotient estimate
            mod_quo  <= mod_prod[31:24];
            mod_step <= 1'b1;
          end else if (mod_to_ptr) begin
            pointer <= mod_fix[AW-1:0];
            phase   <= PH_DATA;
            state   <= S_EMIT;
          end else begin
            enq_off <= mod_fix[AW-1:0];
            if (q_full) begin
              res_flushed <= 1'b1;
              enq_after   <= 1'b1;
              state       <= S_FLUSH;
            end else begin
              state <= S_ENQ;
            end
          end
        end
        S_ENQ: begin
          count <= count + 1'b1;
          state <= S_EMIT;
        end
        S_FLUSH: begin
          // read one entry a cycle, write it to the store the cycle after
          fl_pend <= fl_issue;
          if (fl_issue) begin
            fl_idx <= fl_idx + 1'b1;
          end
          if (fl_done) begin
            count <= '0;
            state <= enq_after ? S_ENQ : S_EMIT;
          end
        end
        S_RDADDR: begin
          pointer <= ptr_inc;
          state   <= S_RDDATA;
        end
        S_RDDATA: begin
          res_rd <= st_rdata;
          state  <= S_EMIT;
        end
        default: begin
          // hold the result until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {6'd0, res_flushed, 8'(count), protect, res_rd};
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Checks on queue and pointer bookkeeping
  `I2CESW_ASSERT_ALWAYS(a_count_bound, count <= CW'(QUEUE_DEPTH), "queue count overflow")
  `I2CESW_ASSERT_IMPLY(a_enq_room, state == S_ENQ, count < CW'(QUEUE_DEPTH), "append to full queue")
  `I2CESW_ASSERT_NEXT(a_flush_clears, state == S_FLUSH && fl_done, count == '0, "commit left entries")
  `I2CESW_ASSERT_ALWAYS(a_ptr_bound, pointer <= AW'(MEM_BYTES - 1), "pointer beyond store")

endmodule

>>> sv/i2cesw_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module i2cesw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read at one address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
